// ----- hw/rtl/ifd_pkg.sv -----
// Shared types, constants and the CRC-16/ARC byte update for the IMU frame deframer.
// Used by ifd_deframe and imu_frame_deframer_crc16_core; no other dependencies.
package ifd_pkg;

  localparam int unsigned FrameBytesDefault = 82;

  localparam logic [7:0] HeaderReset = 8'd90;
  localparam logic [7:0] TypeReset   = 8'd165;

  // Configuration register indexes
  localparam logic [7:0] CfgHeaderIdx = 8'd0;
  localparam logic [7:0] CfgTypeIdx   = 8'd1;

  // Frame layout: received CRC sits at bytes 4 (low) and 5 (high)
  localparam logic [7:0] CrcLoPos  = 8'd4;
  localparam logic [7:0] CrcHiPos  = 8'd5;
  localparam logic [7:0] TypePos   = 8'd1;
  localparam logic [7:0] BodyStart = 8'd2;

  localparam logic [15:0] CrcPolyRefl = 16'hA001;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  byte_offset;
    logic        frame_last;
    logic        crc_ok;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic [31:0] good_frames;
  } result_t;

  // One reflected CRC-16/ARC byte step, LSB first.
  function automatic logic [15:0] crc_arc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPolyRefl;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/ifd_deframe.sv -----
// Input register, sync state machine, CRC accumulator and good-frame counter.
// Depends on ifd_pkg for result_t, frame layout constants and crc_arc_byte.
module ifd_deframe import ifd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] header_value_i,
  input  logic [7:0] type_value_i,
  input  logic       out_free_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [7:0] LastPos = 8'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhType = 2'd1,
    PhBody = 2'd2
  } phase_e;

  logic        in_valid_q;
  logic [7:0]  rx_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] cap_q, cap_d;
  logic [31:0] good_q, good_d;
  logic        fire;
  logic        emit;
  logic        last;
  logic        ok;
  logic [15:0] crc_zero;
  logic [15:0] crc_acc;

  // Process the held byte when the result side can take it
  assign fire       = in_valid_q && out_free_i;
  assign in_ready_o = !in_valid_q || fire;

  assign crc_zero = crc_arc_byte(16'h0000, rx_q);
  assign crc_acc  = crc_arc_byte(crc_q, rx_q);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    cap_d   = cap_q;
    good_d  = good_q;
    emit    = 1'b0;
    last    = 1'b0;
    ok      = 1'b0;
    unique case (phase_q)
      PhType: begin
        if (rx_q == type_value_i) begin
          crc_d   = crc_acc;
          pos_d   = BodyStart;
          phase_d = PhBody;
        end else if (rx_q == header_value_i) begin
          crc_d   = crc_zero;
          pos_d   = TypePos;
          phase_d = PhType;
        end else begin
          pos_d   = 8'd0;
          phase_d = PhHunt;
        end
      end
      PhBody: begin
        emit = 1'b1;
        if (pos_q == CrcLoPos) begin
          cap_d = {cap_q[15:8], rx_q};
        end else if (pos_q == CrcHiPos) begin
          cap_d = {rx_q, cap_q[7:0]};
        end else begin
          crc_d = crc_acc;
        end
        last = (pos_q >= LastPos);
        if (last) begin
          ok      = (crc_d == cap_d);
          good_d  = ok ? good_q + 32'd1 : good_q;
          pos_d   = 8'd0;
          phase_d = PhHunt;
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
      default: begin
        // Hunting, and any unused phase code
        phase_d = PhHunt;
        if (rx_q == header_value_i) begin
          crc_d   = crc_zero;
          pos_d   = TypePos;
          phase_d = PhType;
        end
      end
    endcase
  end

  always_comb begin
    res_valid_o        = fire && emit;
    res_o.data_byte    = rx_q;
    res_o.byte_offset  = pos_q;
    res_o.frame_last   = last;
    res_o.crc_ok       = last && ok;
    res_o.received_crc = last ? cap_d : 16'h0000;
    res_o.computed_crc = last ? crc_d : 16'h0000;
    res_o.good_frames  = last ? good_d : 32'h0000_0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PhHunt;
      pos_q      <= 8'd0;
      crc_q      <= 16'h0000;
      cap_q      <= 16'h0000;
      good_q     <= 32'h0000_0000;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        crc_q   <= crc_d;
        cap_q   <= cap_d;
        good_q  <= good_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rx_q <= rx_byte_i;
    end
  end

endmodule

// ----- hw/rtl/imu_frame_deframer_crc16_core.sv -----
// Top level of the IMU frame deframer: configuration registers and result register.
// Depends on ifd_pkg and instantiates ifd_deframe.
//
// Usage:
//   Feed received serial bytes on the input channel (in_valid_i/in_ready_o,
//   rx_byte_i). The block hunts for header_value, requires type_value right
//   after it, then emits every frame byte from offset 2 on as one result
//   transaction with its offset. The final byte of a frame (offset
//   FRAME_BYTES-1) carries frame_last, crc_ok, the received and computed
//   CRC-16/ARC and the wrapping good-frame count; those fields read zero on
//   other bytes. Header, type and out-of-frame bytes give no result.
//   Every frame resyncs on its own header, pass or fail.
// Timing:
//   A byte lands in the input register, is processed in one pass and its
//   result loads into the result register once that register is free.
//   One byte per cycle is sustained while out_ready_i stays high; the
//   input and result registers decouple the two channels.
// Stall: when out_ready_i is low the held result stays put and processing
//   pauses; in_ready_o drops once the input register is also full.
// Reset: both registers read as empty, state goes back to hunting, CRC
//   and counter clear, header/type return to 90 and 165. Configuration
//   writes are always taken (cfg_ready_o high); unknown indexes are ignored.
module imu_frame_deframer_crc16_core import ifd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  byte_offset_o,
  output logic        frame_last_o,
  output logic        crc_ok_o,
  output logic [15:0] received_crc_o,
  output logic [15:0] computed_crc_o,
  output logic [31:0] good_frames_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [7:0] LastPos = 8'(FRAME_BYTES - 1);

  logic [7:0] header_q;
  logic [7:0] type_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic       res_valid;
  logic       out_free;

  assign cfg_ready_o = 1'b1;

  // Result register may load when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  ifd_deframe #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_deframe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .header_value_i(header_q),
    .type_value_i  (type_q),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      type_q   <= TypeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgHeaderIdx: header_q <= cfg_data_i;
        CfgTypeIdx:   type_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Result register: load on a new result, drop after the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_q.data_byte;
  assign byte_offset_o  = out_q.byte_offset;
  assign frame_last_o   = out_q.frame_last;
  assign crc_ok_o       = out_q.crc_ok;
  assign received_crc_o = out_q.received_crc;
  assign computed_crc_o = out_q.computed_crc;
  assign good_frames_o  = out_q.good_frames;

`ifndef ASSERT_OFF
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_offset_o >= BodyStart) && (byte_offset_o <= LastPos))
    else $error("result offset outside frame body");

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_last_o == (byte_offset_o == LastPos)))
    else $error("frame_last does not match final offset");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_last_o) |->
      (!crc_ok_o && received_crc_o == 16'h0000 && computed_crc_o == 16'h0000
       && good_frames_o == 32'h0000_0000))
    else $error("frame status set on a non-final byte");

  a_ok_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |->
      (crc_ok_o == (received_crc_o == computed_crc_o)))
    else $error("crc_ok disagrees with CRC values");
`endif

endmodule
